FILE: hdl/ordered_list_insert_remove_defines.svh
// Assertion macros for the ordered list block.
// Taken in by the checker; expects clk and rst_n in scope at the point of use.
`ifndef ORDERED_LIST_INSERT_REMOVE_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_DEFINES_SVH

// same-cycle implication
`define OLI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered list check failed");

// next-cycle implication
`define OLI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered list check failed");

`endif

FILE: hdl/oli_pkg.sv
// Shared constants, codes and types of the ordered list block.
// No dependencies; used by every other file except ordered_list_insert_remove_defines.svh.
`default_nettype none

package oli_pkg;

  localparam int DEPTH   = 64;
  localparam int ELEM_W  = 32;
  localparam int REQ_W   = 2;
  localparam int ST_W    = 2;
  localparam int POS_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int GROUP   = 8;
  localparam int NGROUP  = DEPTH / GROUP;
  localparam int GSEL_W  = $clog2(GROUP);
  localparam int NG_W    = $clog2(NGROUP);

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GET    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SET    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SHIFT  = 2'd2,
    CMD_SET    = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/oli_if.sv
// Request and result channel interfaces of the ordered list block.
// Depends on oli_pkg for field widths.
`default_nettype none

interface oli_in_if import oli_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  remove_count;
  logic [ELEM_W-1:0] element_value;

  modport source (output valid, req_type, position, remove_count, element_value,
                  input ready);
  modport sink (input valid, req_type, position, remove_count, element_value,
                output ready);
endinterface

interface oli_out_if import oli_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [ELEM_W-1:0] read_value;
  logic [POS_W-1:0]  length_now;

  modport source (output valid, status, read_value, length_now, input ready);
  modport sink (input valid, status, read_value, length_now, output ready);
endinterface

`default_nettype wire

FILE: hdl/ordered_list_insert_remove.sv
// Ordered list of up to DEPTH elements: a row of storage cells, a read tree
// and a request sequencer. Depends on oli_pkg, oli_if, oli_cell, oli_rdsel, oli_ctrl.
//
// Usage:
//   in_ch carries one request per item: insert, remove, get or set, with a
//   position, a remove count and an element value. out_ch returns exactly one
//   result item per request: status, the value read by a get, and the list
//   length after the request. Both channels move an item when valid and ready
//   are high at a rising clock edge.
//   Insert, set and any rejected request load the result register when taken;
//   a get loads the group registers of the two-level registered read tree and
//   then the result register; a remove shifts the cell row down by one place
//   per cycle and loads its result with the last shift. One item is in work at
//   a time; the next is accepted once the result register is empty or is being
//   taken in that cycle. Reset clears the state, the length and the result valid
//   flag; element storage is not cleared and needs no clearing pass.
//   A result waiting with out_ch.ready low holds, and no new request is taken.
`default_nettype none

module ordered_list_insert_remove import oli_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  oli_in_if.sink    in_ch,
  oli_out_if.source out_ch
);

  logic [ELEM_W-1:0] cell_val [DEPTH];
  logic [ELEM_W-1:0] grp [NGROUP];
  logic              rd_load;
  cell_ctl_t         cell_ctl;
  logic [POS_W-1:0]  rd_pos;

  assign rd_pos = in_ch.position;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_W-1:0] lo;
    logic [ELEM_W-1:0] hi;
    if (i == 0) begin : g_first
      assign lo = '0;
    end else begin : g_mid_lo
      assign lo = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign hi = cell_val[i];
    end else begin : g_mid_hi
      assign hi = cell_val[i+1];
    end
    oli_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(i)),
      .ctl     (cell_ctl),
      .from_lo (lo),
      .from_hi (hi),
      .value   (cell_val[i])
    );
  end

  oli_rdsel u_rdsel (
    .clk   (clk),
    .cells (cell_val),
    .load  (rd_load),
    .sel   (rd_pos[GSEL_W-1:0]),
    .grp   (grp)
  );

  oli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .grp      (grp),
    .rd_load  (rd_load),
    .cell_ctl (cell_ctl)
  );

endmodule

`default_nettype wire

FILE: hdl/oli_cell.sv
// One storage cell of the list row: holds one element and takes its
// neighbour's value on insert or shift, or the request value at its own position on insert or set. Depends on oli_pkg.
`default_nettype none

module oli_cell import oli_pkg::*; (
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_ctl_t         ctl,
  input  logic [ELEM_W-1:0] from_lo,
  input  logic [ELEM_W-1:0] from_hi,
  output logic [ELEM_W-1:0] value
);

  logic [ELEM_W-1:0] val_r;
  logic [ELEM_W-1:0] val_nxt;
  logic [POS_W-1:0]  idx_ext;

  assign idx_ext = POS_W'(idx);

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.cmd)
      CMD_HOLD: begin
      end
      CMD_INSERT: begin
        if (idx_ext > ctl.pos) begin
          val_nxt = from_lo;
        end else if (idx_ext == ctl.pos) begin
          val_nxt = ctl.value;
        end
      end
      CMD_SHIFT: begin
        if (idx_ext >= ctl.pos) begin
          val_nxt = from_hi;
        end
      end
      CMD_SET: begin
        if (idx_ext == ctl.pos) begin
          val_nxt = ctl.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign value = val_r;

endmodule

`default_nettype wire

FILE: hdl/oli_rdsel.sv
// First stage of the registered read tree: one element per group of cells.
// Depends on oli_pkg.
`default_nettype none

module oli_rdsel import oli_pkg::*; (
  input  logic              clk,
  input  logic [ELEM_W-1:0] cells [DEPTH],
  input  logic              load,
  input  logic [GSEL_W-1:0] sel,
  output logic [ELEM_W-1:0] grp [NGROUP]
);

  logic [ELEM_W-1:0] grp_r [NGROUP];

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NGROUP; g++) begin
        grp_r[g] <= cells[{NG_W'(g), sel}];
      end
    end
  end

  assign grp = grp_r;

endmodule

`default_nettype wire

FILE: hdl/oli_ctrl.sv
// Request sequencer: checks, list length, cell commands and result register.
// Depends on oli_pkg and the channel interfaces.
`default_nettype none

module oli_ctrl import oli_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  oli_in_if.sink            in_ch,
  oli_out_if.source         out_ch,
  input  logic [ELEM_W-1:0] grp [NGROUP],
  output logic              rd_load,
  output cell_ctl_t         cell_ctl
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [ELEM_W-1:0] out_data_r, out_data_nxt;
  logic [POS_W-1:0]  out_len_r, out_len_nxt;

  logic              in_ready;
  logic              acc;
  logic [POS_W:0]    end_pos;
  logic              pos_ge_len;

  assign in_ready   = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign acc        = in_ch.valid && in_ready;
  assign end_pos    = {1'b0, in_ch.position} + {1'b0, in_ch.remove_count};
  assign pos_ge_len = in_ch.position >= len_r;

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_len_nxt    = out_len_r;
    rd_load        = 1'b0;
    cell_ctl.cmd   = CMD_HOLD;
    cell_ctl.pos   = in_ch.position;
    cell_ctl.value = in_ch.element_value[ELEM_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_data_nxt = '0;
          unique case (in_ch.req_type)
            REQ_INSERT: begin
              out_valid_nxt = 1'b1;
              if (in_ch.position > len_r) begin
                out_status_nxt = ST_INVALID;
              end else if (len_r == POS_W'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_OK;
                cell_ctl.cmd   = CMD_INSERT;
                len_nxt        = len_r + POS_W'(1);
              end
              out_len_nxt = len_nxt;
            end
            REQ_REMOVE: begin
              if (in_ch.remove_count == '0 || pos_ge_len || end_pos > {1'b0, len_r}) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_INVALID;
                out_len_nxt    = len_r;
              end else begin
                state_nxt = S_SHIFT;
                pos_nxt   = in_ch.position;
                cnt_nxt   = in_ch.remove_count;
                len_nxt   = len_r - in_ch.remove_count;
              end
            end
            REQ_GET: begin
              if (pos_ge_len) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_INVALID;
                out_len_nxt    = len_r;
              end else begin
                state_nxt = S_READ;
                pos_nxt   = in_ch.position;
                rd_load   = 1'b1;
              end
            end
            REQ_SET: begin
              out_valid_nxt = 1'b1;
              out_len_nxt   = len_r;
              if (pos_ge_len) begin
                out_status_nxt = ST_INVALID;
              end else begin
                out_status_nxt = ST_OK;
                cell_ctl.cmd   = CMD_SET;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        cell_ctl.cmd = CMD_SHIFT;
        cell_ctl.pos = pos_r;
        cnt_nxt      = cnt_r - POS_W'(1);
        if (cnt_r == POS_W'(1)) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = '0;
          out_len_nxt    = len_r;
        end
      end
      S_READ: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_data_nxt   = grp[pos_r[IDX_W-1:GSEL_W]];
        out_len_nxt    = len_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_value = out_data_r;
  assign out_ch.length_now = out_len_r;

endmodule

`default_nettype wire

FILE: hdl/oli_chk.sv
// Port-level checker of the ordered list block, bound to the top level.
// Depends on oli_pkg and ordered_list_insert_remove_defines.svh.
`default_nettype none
`include "ordered_list_insert_remove_defines.svh"

module oli_chk import oli_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ST_W-1:0]   out_status,
  input logic [ELEM_W-1:0] out_read_value,
  input logic [POS_W-1:0]  out_length_now
);

  `OLI_ASSERT_IMP(a_fail_zero, out_valid && out_status != ST_OK, out_read_value == '0)
  `OLI_ASSERT_IMP(a_full_len, out_valid && out_status == ST_FULL, out_length_now == POS_W'(DEPTH))
  `OLI_ASSERT_IMP(a_len_bound, out_valid, out_length_now <= POS_W'(DEPTH))
  `OLI_ASSERT_IMP(a_no_overrun, in_valid && in_ready, !out_valid || out_ready)
  `OLI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_length_now) && $stable(out_status))

endmodule

bind ordered_list_insert_remove oli_chk u_oli_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_read_value (out_ch.read_value),
  .out_length_now (out_ch.length_now)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for ordered_list_insert_remove: drives requests, predicts each result.
// Depends on oli_pkg, oli_in_if / oli_out_if and the block itself.
`default_nettype none

module testbench;
  import oli_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ELEM_W-1:0] read_value;
    logic [POS_W-1:0]  length_now;
  } list_result_t;

  class list_scoreboard;
    logic [ELEM_W-1:0] cells [DEPTH];
    int                list_len;
    list_result_t      expected_q [$];
    int                errors;

    function new();
      list_len = 0;
      errors   = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function void note_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                               input logic [POS_W-1:0] cnt, input logic [ELEM_W-1:0] val);
      list_result_t res;
      int           p;
      int           c;
      p              = pos;
      c              = cnt;
      res.status     = ST_OK;
      res.read_value = '0;
      case (kind)
        REQ_INSERT: begin
          if (p > list_len) begin
            res.status = ST_INVALID;
          end else if (list_len >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            for (int i = list_len; i > p; i--) cells[i] = cells[i-1];
            cells[p] = val;
            list_len++;
          end
        end
        REQ_REMOVE: begin
          if (c < 1 || p >= list_len || p + c > list_len) begin
            res.status = ST_INVALID;
          end else begin
            for (int i = 0; p + c + i < list_len; i++) cells[p+i] = cells[p+c+i];
            list_len -= c;
          end
        end
        REQ_GET: begin
          if (p >= list_len) res.status = ST_INVALID;
          else res.read_value = cells[p];
        end
        REQ_SET: begin
          if (p >= list_len) res.status = ST_INVALID;
          else cells[p] = val;
        end
      endcase
      res.length_now = POS_W'(list_len);
      expected_q.push_back(res);
    endfunction

    function void compare_field(input string field_name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field_name, want, got);
      end
    endfunction

    function void check_result(input logic [ST_W-1:0] st, input logic [ELEM_W-1:0] rd,
                               input logic [POS_W-1:0] len);
      list_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual status %0h value %0h length %0h",
                 $time, st, rd, len);
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, st);
      compare_field("read_value", want.read_value, rd);
      compare_field("length_now", want.length_now, len);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   send_idle = 0;
  int   stall_pct = 0;
  int   hold_requests = 0;
  bit   filling = 1'b1;
  int   boundary_hits = 0;

  list_scoreboard sb = new();

  oli_in_if  in_ch ();
  oli_out_if out_ch ();

  ordered_list_insert_remove i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: check, then choose ready for the next cycle
  initial begin
    int hold_left;
    int hold_served;
    hold_left    = 0;
    hold_served  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.status, out_ch.read_value, out_ch.length_now);
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic offer(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                       input logic [POS_W-1:0] cnt, input logic [ELEM_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= kind;
    in_ch.position      <= pos;
    in_ch.remove_count  <= cnt;
    in_ch.element_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(kind, pos, cnt, val);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic random_request();
    int                len;
    int                r;
    int                p;
    int                c;
    logic [REQ_W-1:0]  kind;
    logic [ELEM_W-1:0] val;
    len = sb.list_len;
    r   = $urandom_range(0, 99);
    if (r < 10) begin
      kind = REQ_W'($urandom_range(0, 3));
      offer(kind, POS_W'($urandom_range(0, 127)), POS_W'($urandom_range(0, 127)), $urandom);
      return;
    end
    r = $urandom_range(0, 99);
    if (filling)
      kind = r < 55 ? REQ_INSERT : r < 70 ? REQ_GET : r < 85 ? REQ_SET : REQ_REMOVE;
    else
      kind = r < 20 ? REQ_INSERT : r < 35 ? REQ_GET : r < 50 ? REQ_SET : REQ_REMOVE;
    r = $urandom_range(0, 99);
    if (r < 70)
      p = (kind == REQ_INSERT) ? $urandom_range(0, len) : (len == 0 ? 0 : $urandom_range(0, len - 1));
    else if (r < 80) p = len;
    else if (r < 88) p = (len == 0) ? 0 : len - 1;
    else if (r < 94) p = DEPTH;
    else p = $urandom_range(0, 127);
    r = $urandom_range(0, 99);
    if (p >= len) c = $urandom_range(0, 3);
    else if (filling || r < 55) c = $urandom_range(1, (len - p < 3) ? len - p : 3);
    else if (r < 72) c = len - p;
    else if (r < 80) c = 0;
    else if (r < 88) c = len - p + 1;
    else c = $urandom_range(0, 127);
    r = $urandom_range(0, 99);
    if (r < 5) val = '0;
    else if (r < 10) val = '1;
    else val = $urandom;
    offer(kind, POS_W'(p), POS_W'(c), val);
  endtask

  task automatic run_random(input int n, input int idle_in, input int stall_out);
    send_idle = idle_in;
    stall_pct = stall_out;
    repeat (n) begin
      random_request();
      if (filling && sb.list_len == DEPTH) boundary_hits++;
      if (!filling && sb.list_len == 0) boundary_hits++;
      if (boundary_hits >= 4) begin
        filling       = !filling;
        boundary_hits = 0;
      end
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= REQ_GET;
    in_ch.position      <= '0;
    in_ch.remove_count  <= '0;
    in_ch.element_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    offer(REQ_GET, 0, 0, '0);
    offer(REQ_SET, 0, 0, 32'h1111_1111);
    offer(REQ_REMOVE, 0, 1, '0);
    offer(REQ_INSERT, 1, 0, 32'h2222_2222);
    offer(REQ_INSERT, 0, 0, 32'h0000_0000);
    offer(REQ_INSERT, 1, 0, 32'hFFFF_FFFF);
    offer(REQ_INSERT, 0, 0, 32'hA5A5_A5A5);
    offer(REQ_INSERT, 1, 0, 32'h5A5A_5A5A);
    for (int i = 0; i < 4; i++) offer(REQ_GET, POS_W'(i), 0, '0);
    offer(REQ_SET, 3, 0, 32'h1234_5678);
    offer(REQ_GET, 127, 0, '0);
    offer(REQ_SET, 4, 0, 32'h8765_4321);
    offer(REQ_REMOVE, 0, 0, '0);
    offer(REQ_REMOVE, 2, 3, '0);
    offer(REQ_REMOVE, 4, 1, '0);
    offer(REQ_REMOVE, 1, 127, '0);
    offer(REQ_REMOVE, 2, 2, '0);
    offer(REQ_GET, 1, 0, '0);
    offer(REQ_REMOVE, 0, 2, '0);
    offer(REQ_INSERT, 64, 0, 32'h3333_3333);

    run_random(450, 0, 0);
    run_random(450, 53, 0);

    // hold the result side off while requests keep coming
    hold_requests <= hold_requests + 1;
    run_random(40, 0, 0);
    drain_results();

    run_random(450, 0, 53);
    run_random(450, 17, 17);

    drain_results();
    repeat (80) @(posedge clk);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hdl
hdl/oli_pkg.sv
hdl/oli_if.sv
hdl/oli_cell.sv
hdl/oli_rdsel.sv
hdl/oli_ctrl.sv
hdl/ordered_list_insert_remove.sv
hdl/oli_chk.sv
tb/sv/testbench.sv
